FILE: rtl/ps2mt_pkg.sv
// ---------------------------------------------------------------------------
// PS/2 mouse packet tracker package
// Shared widths, register indexes, phase codes and record types.
// ---------------------------------------------------------------------------
package ps2mt_pkg;

   localparam int POS_WIDTH   = 24;
   localparam int FRAME_WIDTH = 32;
   localparam int BYTE_WIDTH  = 8;
   localparam int CSR_IDX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = POS_WIDTH;
   localparam int PROD_WIDTH  = 2 * BYTE_WIDTH + 1;
   // Wide enough that position plus or minus a scaled byte never wraps.
   localparam int SUM_WIDTH   = ((POS_WIDTH > PROD_WIDTH) ? POS_WIDTH : PROD_WIDTH) + 1;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_TIMEOUT = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SCALE_X = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SCALE_Y = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_X_MIN   = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_X_MAX   = 3'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_Y_MIN   = 3'd5;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_Y_MAX   = 3'd6;

   localparam logic [BYTE_WIDTH-1:0] TIMEOUT_RESET = 8'd2;
   localparam logic [BYTE_WIDTH-1:0] SCALE_X_RESET = 8'd27;
   localparam logic [BYTE_WIDTH-1:0] SCALE_Y_RESET = 8'd36;
   localparam logic signed [POS_WIDTH-1:0] POS_MAX_RESET = {1'b0, {(POS_WIDTH-1){1'b1}}};

   typedef enum logic [2:0] {
      PHASE_FLAG = 3'b001,
      PHASE_X    = 3'b010,
      PHASE_Y    = 3'b100
   } phase_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0]        timeout_frames;
      logic [BYTE_WIDTH-1:0]        scale_x;
      logic [BYTE_WIDTH-1:0]        scale_y;
      logic signed [POS_WIDTH-1:0]  x_min;
      logic signed [POS_WIDTH-1:0]  x_max;
      logic signed [POS_WIDTH-1:0]  y_min;
      logic signed [POS_WIDTH-1:0]  y_max;
   } cfg_type;

   typedef struct packed {
      logic signed [BYTE_WIDTH-1:0] rx_byte;
      logic [FRAME_WIDTH-1:0]       frame_index;
   } req_type;

   typedef struct packed {
      logic                         click_changed;
      logic                         click_down;
      logic                         position_valid;
      logic signed [POS_WIDTH-1:0]  cursor_x;
      logic signed [POS_WIDTH-1:0]  cursor_y;
   } rsp_type;

endpackage

FILE: rtl/ps2mt_if.sv
// ---------------------------------------------------------------------------
// PS/2 mouse packet tracker channel interfaces
// Valid/ready channels for bytes in, results out and register writes.
// ---------------------------------------------------------------------------
interface ps2mt_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [ps2mt_pkg::BYTE_WIDTH-1:0] rx_byte;
   logic [ps2mt_pkg::FRAME_WIDTH-1:0]      frame_index;

   modport source (output valid, output rx_byte, output frame_index, input ready);
   modport sink   (input valid, input rx_byte, input frame_index, output ready);
endinterface

interface ps2mt_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   click_changed;
   logic                                   click_down;
   logic                                   position_valid;
   logic signed [ps2mt_pkg::POS_WIDTH-1:0] cursor_x;
   logic signed [ps2mt_pkg::POS_WIDTH-1:0] cursor_y;

   modport source (output valid, output click_changed, output click_down,
                   output position_valid, output cursor_x, output cursor_y, input ready);
   modport sink   (input valid, input click_changed, input click_down,
                   input position_valid, input cursor_x, input cursor_y, output ready);
endinterface

interface ps2mt_csr_if;
   logic                                      valid;
   logic                                      ready;
   logic [ps2mt_pkg::CSR_IDX_WIDTH-1:0]       index;
   logic [ps2mt_pkg::CSR_DATA_WIDTH-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/ps2_mouse_packet_tracker.sv
// ---------------------------------------------------------------------------
// PS/2 mouse packet tracker
// Decodes three-byte mouse packets into button state and a clamped cursor.
// ---------------------------------------------------------------------------
// Path: an accepted byte is held in the input register, and its result is
//   loaded into the result register when the byte advances.
// Throughput: one byte per cycle while the result register is not held.
// Stalls: a byte waits in the input register while the result register is held.
// Reset: synchronous, empties both stages, clears phase, button, frame and
//   cursor, and loads the register defaults.
module ps2_mouse_packet_tracker (
   input  logic        clock,
   input  logic        reset,
   ps2mt_req_if.sink   req_ch,
   ps2mt_rsp_if.source rsp_ch,
   ps2mt_csr_if.sink   csr_ch
);
   import ps2mt_pkg::*;

   cfg_type cfg;
   req_type item_ff;
   logic    item_valid_ff;
   rsp_type result;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;
   logic    advance;

   // The held byte moves on when the result register is free or being taken.
   assign advance      = item_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !item_valid_ff || advance;

   ps2mt_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   ps2mt_track u_track (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .cfg     (cfg),
      .item    (item_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_ch.ready) item_valid_ff <= req_ch.valid;
         if (advance) rsp_valid_ff <= 1'b1;
         else if (rsp_ch.ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         item_ff.rx_byte     <= req_ch.rx_byte;
         item_ff.frame_index <= req_ch.frame_index;
      end
      if (advance) rsp_ff <= result;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.click_changed  = rsp_ff.click_changed;
   assign rsp_ch.click_down     = rsp_ff.click_down;
   assign rsp_ch.position_valid = rsp_ff.position_valid;
   assign rsp_ch.cursor_x       = rsp_ff.cursor_x;
   assign rsp_ch.cursor_y       = rsp_ff.cursor_y;

endmodule

FILE: rtl/ps2mt_csr.sv
// ---------------------------------------------------------------------------
// PS/2 mouse packet tracker configuration registers
// Holds timeout, scale factors and cursor limits written over the CSR channel.
// ---------------------------------------------------------------------------
module ps2mt_csr (
   input  logic                clock,
   input  logic                reset,
   ps2mt_csr_if.sink           csr_ch,
   output ps2mt_pkg::cfg_type  cfg
);
   import ps2mt_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_TIMEOUT: cfg_in.timeout_frames = csr_ch.data[BYTE_WIDTH-1:0];
            CSR_SCALE_X: cfg_in.scale_x        = csr_ch.data[BYTE_WIDTH-1:0];
            CSR_SCALE_Y: cfg_in.scale_y        = csr_ch.data[BYTE_WIDTH-1:0];
            CSR_X_MIN:   cfg_in.x_min          = $signed(csr_ch.data[POS_WIDTH-1:0]);
            CSR_X_MAX:   cfg_in.x_max          = $signed(csr_ch.data[POS_WIDTH-1:0]);
            CSR_Y_MIN:   cfg_in.y_min          = $signed(csr_ch.data[POS_WIDTH-1:0]);
            CSR_Y_MAX:   cfg_in.y_max          = $signed(csr_ch.data[POS_WIDTH-1:0]);
            default: begin
               // Writes beyond the last register are dropped.
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_frames <= TIMEOUT_RESET;
         cfg_ff.scale_x        <= SCALE_X_RESET;
         cfg_ff.scale_y        <= SCALE_Y_RESET;
         cfg_ff.x_min          <= '0;
         cfg_ff.x_max          <= POS_MAX_RESET;
         cfg_ff.y_min          <= '0;
         cfg_ff.y_max          <= POS_MAX_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/ps2mt_track.sv
// ---------------------------------------------------------------------------
// PS/2 mouse packet tracker state and update logic
// Keeps phase, button, last frame and cursor; forms one result per byte.
// ---------------------------------------------------------------------------
module ps2mt_track (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  ps2mt_pkg::cfg_type  cfg,
   input  ps2mt_pkg::req_type  item,
   output ps2mt_pkg::rsp_type  result
);
   import ps2mt_pkg::*;

   phase_type                    phase_ff, phase_in, phase_cur;
   logic                         left_ff, left_in;
   logic [FRAME_WIDTH-1:0]       last_frame_ff, last_frame_in;
   logic signed [POS_WIDTH-1:0]  pos_x_ff, pos_x_in;
   logic signed [POS_WIDTH-1:0]  pos_y_ff, pos_y_in;

   logic [FRAME_WIDTH-1:0]       frame_gap;
   logic signed [PROD_WIDTH-1:0] prod_x, prod_y;
   logic signed [SUM_WIDTH-1:0]  sum_x, sum_y;

   function automatic logic signed [POS_WIDTH-1:0] clamp_pos(
      input logic signed [SUM_WIDTH-1:0] v,
      input logic signed [POS_WIDTH-1:0] lo,
      input logic signed [POS_WIDTH-1:0] hi
   );
      logic signed [SUM_WIDTH-1:0] r;
      r = v;
      if (r < SUM_WIDTH'(lo)) r = SUM_WIDTH'(lo);
      if (r > SUM_WIDTH'(hi)) r = SUM_WIDTH'(hi);
      return r[POS_WIDTH-1:0];
   endfunction

   always_comb begin
      // Unsigned modular difference, so a wrapped frame counter is harmless.
      frame_gap = item.frame_index - last_frame_ff;
      phase_cur = (frame_gap > FRAME_WIDTH'(cfg.timeout_frames)) ? PHASE_FLAG : phase_ff;

      prod_x = $signed({1'b0, cfg.scale_x}) * item.rx_byte;
      prod_y = $signed({1'b0, cfg.scale_y}) * item.rx_byte;

      left_in = left_ff;
      sum_x   = SUM_WIDTH'(pos_x_ff);
      sum_y   = SUM_WIDTH'(pos_y_ff);
      unique case (phase_cur)
         PHASE_FLAG: begin
            left_in  = item.rx_byte[0];
            phase_in = PHASE_X;
         end
         PHASE_X: begin
            sum_x    = SUM_WIDTH'(pos_x_ff) + SUM_WIDTH'(prod_x);
            phase_in = PHASE_Y;
         end
         PHASE_Y: begin
            sum_y    = SUM_WIDTH'(pos_y_ff) - SUM_WIDTH'(prod_y);
            phase_in = PHASE_FLAG;
         end
         default: phase_in = PHASE_FLAG;
      endcase

      pos_x_in      = clamp_pos(sum_x, cfg.x_min, cfg.x_max);
      pos_y_in      = clamp_pos(sum_y, cfg.y_min, cfg.y_max);
      last_frame_in = item.frame_index;

      result.click_changed  = left_in ^ left_ff;
      result.click_down     = left_in;
      result.position_valid = (phase_cur == PHASE_Y);
      result.cursor_x       = pos_x_in;
      result.cursor_y       = pos_y_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PHASE_FLAG;
         left_ff       <= 1'b0;
         last_frame_ff <= '0;
         pos_x_ff      <= '0;
         pos_y_ff      <= '0;
      end else if (advance) begin
         phase_ff      <= phase_in;
         left_ff       <= left_in;
         last_frame_ff <= last_frame_in;
         pos_x_ff      <= pos_x_in;
         pos_y_ff      <= pos_y_in;
      end
   end

endmodule

FILE: rtl/ps2mt_checker.sv
// ---------------------------------------------------------------------------
// PS/2 mouse packet tracker port checker
// Concurrent assertions on the top-level ports, attached by bind.
// ---------------------------------------------------------------------------
module ps2mt_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_ready,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic                                   rsp_click_changed,
   input logic                                   rsp_position_valid,
   input logic signed [ps2mt_pkg::POS_WIDTH-1:0] rsp_cursor_x
);
   import ps2mt_pkg::*;

   // A button change comes only from a flag byte, a completed packet only
   // from the last byte, so both never show in one result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_click_changed && rsp_position_valid))
      else $error("click change and position update in one result");

   // An accepted byte is loaded into the result register at the next edge
   // when the output side is taking results in that cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) ##1 rsp_ready |=> rsp_valid)
      else $error("result missing after acceptance");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_cursor_x)))
      else $error("stalled result dropped or changed");

endmodule

bind ps2_mouse_packet_tracker ps2mt_checker u_ps2mt_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_ch.valid),
   .req_ready          (req_ch.ready),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_click_changed  (rsp_ch.click_changed),
   .rsp_position_valid (rsp_ch.position_valid),
   .rsp_cursor_x       (rsp_ch.cursor_x)
);
